/* sv/mavg_pkg.sv */
`timescale 1ns / 1ps

package mavg_pkg;

    localparam int DEF_MAX_WINDOW  = 256;
    localparam int DEF_SAMPLE_BITS = 32;

    // width register
    localparam int              WIDTH_BITS  = 9;
    localparam logic [8:0]      WIDTH_RESET = 9'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } mavg_state_t;

endpackage

/* sv/moving_average_filter.sv */
`timescale 1ns / 1ps
// Channel       Dir  Handshake                     Payload
// s_axis        in   s_axis_tvalid/s_axis_tready   tdata: sample; tuser: first
// m_axis        out  m_axis_tvalid/m_axis_tready   tdata: average
// width         in   width_wr_en                   width_wr_data
//
// An item that completes the window passes through the delay-line read, the running-sum
// update, the bit-serial divider and the load of the output register before the next
// item can be taken; the load waits while the output register is still full. An item
// that gives no result passes only through the delay-line read and the running-sum update.
// Reset clears the fill count, running sum, write pointer and sets the width to 4;
// the delay line is not cleared. A stalled output holds the result in its register
// while the next item is accepted and summed; the divider result waits in ST_OUT.
module moving_average_filter #(
    parameter int MAX_WINDOW  = mavg_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS,
    parameter int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [DATA_BITS-1:0]            s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic [0:0]                      s_axis_tuser,   // [0] first
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [DATA_BITS-1:0]            m_axis_tdata,   // [SAMPLE_BITS-1:0] average
    input  logic                            width_wr_en,
    input  logic [mavg_pkg::WIDTH_BITS-1:0] width_wr_data
);
    import mavg_pkg::*;

    localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEAVE_BITS = PTR_BITS + 1;
    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
    localparam int REM_BITS = WIDTH_BITS + 1;
    localparam int CNT_BITS = $clog2(SUM_BITS);

    mavg_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [WIDTH_BITS-1:0]         window_reg, window_next;
    logic [WIDTH_BITS-1:0]         fill_reg, fill_next;
    logic [PTR_BITS-1:0]           wp_reg, wp_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          first_reg, first_next;
    logic                          full_reg, full_next;
    logic                          emit_reg, emit_next;
    logic [SUM_BITS-1:0]           quo_reg, quo_next;
    logic [REM_BITS-1:0]           rem_reg, rem_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic                          out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]        out_data_reg, out_data_next;

    logic [WIDTH_BITS-1:0]  eff_w;
    logic [WIDTH_BITS-1:0]  fill_eff;
    logic                   full_now;
    logic [LEAVE_BITS-1:0]  wp_ext;
    logic [LEAVE_BITS-1:0]  w_ext;
    logic [LEAVE_BITS-1:0]  leave_ext;
    logic [PTR_BITS-1:0]    leave_addr;
    logic                   in_accept;
    logic signed [SUM_BITS-1:0] sum_upd;
    logic [REM_BITS-1:0]    rem_shift;
    logic                   rem_ge;
    logic [SUM_BITS-1:0]    quo_signed;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    // hold off items while the width is being written
    assign s_axis_tready = (state_reg == ST_IDLE) && !width_wr_en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'(out_data_reg);

    always_comb
    begin
        if (window_reg == '0)
        begin
            eff_w = WIDTH_BITS'(1);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            eff_w = WIDTH_BITS'(MAX_WINDOW);
        end
        else
        begin
            eff_w = window_reg;
        end
    end

    assign fill_eff = s_axis_tuser[0] ? '0 : fill_reg;
    assign full_now = (fill_eff >= eff_w);

    // oldest sample of the window: wp - w, modulo the line length
    assign wp_ext = {1'b0, wp_reg};
    assign w_ext  = LEAVE_BITS'(eff_w);
    always_comb
    begin
        if (wp_ext >= w_ext)
        begin
            leave_ext = wp_ext - w_ext;
        end
        else
        begin
            leave_ext = wp_ext + LEAVE_BITS'(MAX_WINDOW) - w_ext;
        end
    end
    assign leave_addr = leave_ext[PTR_BITS-1:0];

    // read the leaving entry before the new sample overwrites it
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg <= mem[leave_addr];
            mem[wp_reg] <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    assign sum_upd = (first_reg ? '0 : sum_reg)
                   - (full_reg ? SUM_BITS'(rd_data_reg) : '0)
                   + SUM_BITS'(sample_reg);

    assign rem_shift  = {rem_reg[REM_BITS-2:0], quo_reg[SUM_BITS-1]};
    assign rem_ge     = (rem_shift >= REM_BITS'(eff_w));
    assign quo_signed = neg_reg ? (~quo_reg + SUM_BITS'(1)) : quo_reg;

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        first_next     = first_reg;
        full_next      = full_reg;
        emit_next      = emit_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (width_wr_en)
                begin
                    // new width restarts the fill
                    window_next = width_wr_data;
                    fill_next   = '0;
                    sum_next    = '0;
                end
                else if (in_accept)
                begin
                    sample_next = s_axis_tdata[SAMPLE_BITS-1:0];
                    first_next  = s_axis_tuser[0];
                    full_next   = full_now;
                    fill_next   = full_now ? fill_eff : fill_eff + WIDTH_BITS'(1);
                    emit_next   = full_now || (fill_eff + WIDTH_BITS'(1) == eff_w);
                    wp_next     = (wp_reg == PTR_BITS'(MAX_WINDOW - 1)) ? '0
                                                                       : wp_reg + PTR_BITS'(1);
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next = sum_upd;
                if (emit_reg)
                begin
                    neg_next   = sum_upd[SUM_BITS-1];
                    quo_next   = sum_upd[SUM_BITS-1] ? SUM_BITS'(-sum_upd) : SUM_BITS'(sum_upd);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_shift - REM_BITS'(eff_w) : rem_shift;
                quo_next = {quo_reg[SUM_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = quo_signed[SAMPLE_BITS-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WIDTH_RESET;
            fill_reg      <= '0;
            wp_reg        <= '0;
            sum_reg       <= '0;
            emit_reg      <= 1'b0;
            full_reg      <= 1'b0;
            first_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            emit_reg      <= emit_next;
            full_reg      <= full_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_w)
        else $error("fill count exceeds window width");

    a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !width_wr_en |=> state_reg == ST_SUM)
        else $error("accepted item did not enter sum update");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_BITS'(SUM_BITS - 1))
        else $error("divider ran past its last step");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_valid_reg && !m_axis_tready |=> state_reg == ST_OUT)
        else $error("result dropped while output stalled");

    a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < REM_BITS'(eff_w))
        else $error("divider remainder out of range");

endmodule
